// ----- design/ftj_pkg.sv -----
// Shared types and constants of the full text justifier.
// No dependencies; all but ftj_if and ftj_ram refer to it by scoped names.
package ftj_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int MAX_WORDS = 16;
  localparam int CMD_DEPTH = 4;

  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [5:0] WIDTH_RESET = 6'd16;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_EMIT   = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic       last;
    logic       run_end;
    logic [5:0] len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
    logic       final_line;
    logic       run_end;
  } res_t;

endpackage

// ----- design/ftj_if.sv -----
// Channel interfaces of the full text justifier: input, result and configuration.
// Each carries valid, ready and its payload; no package dependency.
interface ftj_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       word_end;
  logic       text_end;
  modport source (output valid, char_code, word_end, text_end, input ready);
  modport sink (input valid, char_code, word_end, text_end, output ready);
endinterface

interface ftj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       line_end;
  logic       final_line;
  logic       run_end;
  modport source (output valid, out_char, line_end, final_line, run_end, input ready);
  modport sink (input valid, out_char, line_end, final_line, run_end, output ready);
endinterface

interface ftj_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] line_width;
  modport source (output valid, line_width, input ready);
  modport sink (input valid, line_width, output ready);
endinterface

// ----- design/ftj_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ftj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- design/ftj_front.sv -----
// Front end: takes characters, gathers the current word and decides line breaks.
// Uses ftj_pkg and ftj_ram; issues append and emit commands to the command queue.
module ftj_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [5:0]          width,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_code,
  input  logic                word_end,
  input  logic                text_end,
  output logic                push,
  output ftj_pkg::cmd_t       push_cmd,
  input  ftj_pkg::fifo_stat_t fifo_stat,
  input  logic                append_done,
  input  logic                word_re,
  input  logic [4:0]          word_raddr,
  output logic [7:0]          word_rdata
);

  localparam int P_A   = 3;
  localparam int P_APP = 2;
  localparam int P_B   = 1;
  localparam int P_C   = 0;

  logic [5:0] wcc_r;
  logic [4:0] lwc_r;
  logic [5:0] ltl_r;
  logic [3:0] pend_r;
  logic       app_out_r;
  logic [5:0] len_r;
  logic       runa_r;

  logic       acc;
  logic       store;
  logic [5:0] wcnt;
  logic [5:0] len;
  logic [6:0] sum0;
  logic [6:0] sum1;
  logic       ea;
  logic       eb;
  logic       ec;
  logic [4:0] lwc1;
  logic [5:0] ltl1;
  logic [3:0] pend_clr;

  assign in_ready = (pend_r == 4'd0) && !app_out_r;
  assign acc      = in_valid && in_ready;

  always_comb begin
    store = wcc_r < width;
    wcnt  = store ? wcc_r + 6'd1 : wcc_r;
    len   = (wcnt < width) ? wcnt : width;
    sum0  = {1'b0, ltl_r} + {1'b0, len} + {2'b0, lwc_r};
    ea    = (lwc_r >= 5'(ftj_pkg::MAX_WORDS)) || ((lwc_r != 5'd0) && (sum0 > {1'b0, width}));
    lwc1  = ea ? 5'd0 : lwc_r;
    ltl1  = ea ? 6'd0 : ltl_r;
    sum1  = {1'b0, ltl1} + {1'b0, len} + {2'b0, lwc1};
    eb    = sum1 == {1'b0, width};
    ec    = text_end && !eb;
  end

  always_comb begin
    push             = (pend_r != 4'd0) && !fifo_stat.full;
    push_cmd.op      = ftj_pkg::OP_EMIT;
    push_cmd.last    = 1'b0;
    push_cmd.run_end = 1'b1;
    push_cmd.len     = len_r;
    pend_clr         = 4'd0;
    if (pend_r[P_A]) begin
      push_cmd.run_end = runa_r;
      pend_clr[P_A]    = 1'b1;
    end else if (pend_r[P_APP]) begin
      push_cmd.op      = ftj_pkg::OP_APPEND;
      push_cmd.run_end = 1'b0;
      pend_clr[P_APP]  = 1'b1;
    end else if (pend_r[P_B]) begin
      pend_clr[P_B] = 1'b1;
    end else begin
      push_cmd.last = 1'b1;
      pend_clr[P_C] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcc_r     <= 6'd0;
      lwc_r     <= 5'd0;
      ltl_r     <= 6'd0;
      pend_r    <= 4'd0;
      app_out_r <= 1'b0;
    end else begin
      if (push) begin
        pend_r <= pend_r & ~pend_clr;
      end
      if (append_done) begin
        app_out_r <= 1'b0;
      end
      if (acc) begin
        if (word_end || text_end) begin
          wcc_r     <= 6'd0;
          pend_r    <= {ea, 1'b1, eb, ec};
          app_out_r <= 1'b1;
          len_r     <= len;
          runa_r    <= !eb && !ec;
          if (eb || ec) begin
            lwc_r <= 5'd0;
            ltl_r <= 6'd0;
          end else begin
            lwc_r <= lwc1 + 5'd1;
            ltl_r <= ltl1 + len;
          end
        end else begin
          wcc_r <= wcnt;
        end
      end
    end
  end

  ftj_ram #(
    .WIDTH(8),
    .DEPTH(ftj_pkg::MAX_WIDTH)
  ) u_word_ram (
    .clk  (clk),
    .we   (acc && store),
    .waddr(wcc_r[4:0]),
    .wdata(char_code),
    .re   (word_re),
    .raddr(word_raddr),
    .rdata(word_rdata)
  );

endmodule

// ----- design/ftj_cmd_fifo.sv -----
// Short command queue between the front end and the line builder.
// Uses ftj_pkg for the command and status types.
module ftj_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ftj_pkg::cmd_t       push_data,
  input  logic                pop,
  output ftj_pkg::cmd_t       pop_data,
  output ftj_pkg::fifo_stat_t stat
);

  localparam int DEPTH = ftj_pkg::CMD_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  ftj_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = cnt_r == (AW + 1)'(DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        mem_r[wp_r] <= push_data;
        wp_r        <= wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW + 1)'(1);
      end
    end
  end

endmodule

// ----- design/ftj_back.sv -----
// Line builder: appends words to the line store and emits justified lines.
// Uses ftj_pkg and ftj_ram; reads the word store of the front end while appending.
module ftj_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [5:0]          width,
  input  ftj_pkg::fifo_stat_t fifo_stat,
  output logic                pop,
  input  ftj_pkg::cmd_t       cmd,
  output logic                append_done,
  output logic                word_re,
  output logic [4:0]          word_raddr,
  input  logic [7:0]          word_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output ftj_pkg::res_t       out_res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_GEN  = 2'd3;

  localparam logic [1:0] PH_WORD = 2'd0;
  localparam logic [1:0] PH_GAP  = 2'd1;
  localparam logic [1:0] PH_PAD  = 2'd2;

  logic [1:0]    state_r;
  logic [4:0]    n_r;
  logic [5:0]    t_r;
  logic [5:0]    wl_r [ftj_pkg::MAX_WORDS];
  ftj_pkg::cmd_t cmd_r;
  logic [5:0]    j_r;
  logic          wr_v_r;
  logic [5:0]    wr_addr_r;
  logic [3:0]    rem_r;
  logic [4:0]    quo_r;
  logic [2:0]    dbit_r;
  logic          single_r;
  logic [3:0]    i_r;
  logic [5:0]    jc_r;
  logic [4:0]    off_r;
  logic [5:0]    g_r;
  logic [1:0]    ph_r;
  logic [5:0]    k_r;
  logic          s1_v_r;
  logic          s1_space_r;
  logic          s1_le_r;
  logic          s1_fl_r;
  logic          s1_re_r;
  logic          out_v_r;
  ftj_pkg::res_t out_r;

  logic       out_free;
  logic       s1_free;
  logic       gen_adv;
  logic       copy_rd;
  logic       start_single;
  logic [5:0] s_w;
  logic [4:0] s5;
  logic [3:0] div_d;
  logic [4:0] div_try;
  logic       div_ge;
  logic       word_last;
  logic       more_words;
  logic [5:0] gap_len;
  logic       line_last;
  logic [7:0] line_rdata;

  always_comb begin
    out_free     = !out_v_r || out_ready;
    s1_free      = !s1_v_r || out_free;
    gen_adv      = (state_r == ST_GEN) && s1_free;
    pop          = (state_r == ST_IDLE) && !fifo_stat.empty;
    copy_rd      = (state_r == ST_COPY) && (j_r < cmd_r.len);
    append_done  = (state_r == ST_COPY) && !copy_rd;
    word_re      = copy_rd;
    word_raddr   = j_r[4:0];
    start_single = cmd.last || (n_r < 5'd2)
                   || (({1'b0, t_r} + {2'b0, n_r}) > ({1'b0, width} + 7'd1));
    s_w          = width - t_r;
    s5           = s_w[4:0];
    div_d        = 4'(n_r - 5'd1);
    div_try      = {rem_r, s5[dbit_r]};
    div_ge       = div_try >= {1'b0, div_d};
    word_last    = (jc_r + 6'd1) == wl_r[i_r];
    more_words   = ({1'b0, i_r} + 5'd1) < n_r;
    gap_len      = single_r ? 6'd1 : {1'b0, quo_r} + ((i_r < rem_r) ? 6'd1 : 6'd0);
    line_last    = k_r == (width - 6'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= 5'd0;
      t_r     <= 6'd0;
      wr_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            cmd_r    <= cmd;
            j_r      <= 6'd0;
            i_r      <= 4'd0;
            jc_r     <= 6'd0;
            off_r    <= 5'd0;
            k_r      <= 6'd0;
            ph_r     <= (n_r == 5'd0) ? PH_PAD : PH_WORD;
            single_r <= start_single;
            rem_r    <= 4'd0;
            quo_r    <= 5'd0;
            dbit_r   <= 3'd4;
            if (cmd.op == ftj_pkg::OP_APPEND) begin
              state_r <= ST_COPY;
            end else if (start_single) begin
              state_r <= ST_GEN;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_COPY: begin
          if (copy_rd) begin
            j_r <= j_r + 6'd1;
          end else begin
            wl_r[n_r[3:0]] <= cmd_r.len;
            n_r            <= n_r + 5'd1;
            t_r            <= t_r + cmd_r.len;
            state_r        <= ST_IDLE;
          end
        end
        ST_DIV: begin
          rem_r  <= div_ge ? 4'(div_try - {1'b0, div_d}) : div_try[3:0];
          quo_r  <= {quo_r[3:0], div_ge};
          dbit_r <= dbit_r - 3'd1;
          if (dbit_r == 3'd0) begin
            state_r <= ST_GEN;
          end
        end
        ST_GEN: begin
          if (gen_adv) begin
            k_r <= k_r + 6'd1;
            case (ph_r)
              PH_WORD: begin
                off_r <= off_r + 5'd1;
                if (word_last) begin
                  jc_r <= 6'd0;
                  if (more_words) begin
                    ph_r <= PH_GAP;
                    g_r  <= gap_len;
                  end else begin
                    ph_r <= PH_PAD;
                  end
                end else begin
                  jc_r <= jc_r + 6'd1;
                end
              end
              PH_GAP: begin
                if (g_r == 6'd1) begin
                  i_r  <= i_r + 4'd1;
                  ph_r <= PH_WORD;
                end else begin
                  g_r <= g_r - 6'd1;
                end
              end
              default: begin
              end
            endcase
            if (line_last) begin
              state_r <= ST_IDLE;
              n_r     <= 5'd0;
              t_r     <= 6'd0;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      wr_v_r    <= copy_rd;
      wr_addr_r <= t_r + j_r;

      if (out_free) begin
        out_v_r <= s1_v_r;
        if (s1_v_r) begin
          out_r.out_char   <= s1_space_r ? ftj_pkg::SPACE_CHAR : line_rdata;
          out_r.line_end   <= s1_le_r;
          out_r.final_line <= s1_fl_r;
          out_r.run_end    <= s1_re_r;
        end
      end

      if (gen_adv) begin
        s1_v_r     <= 1'b1;
        s1_space_r <= ph_r != PH_WORD;
        s1_le_r    <= line_last;
        s1_fl_r    <= cmd_r.last;
        s1_re_r    <= cmd_r.run_end && line_last;
      end else if (out_free) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  ftj_ram #(
    .WIDTH(8),
    .DEPTH(ftj_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (wr_v_r && (wr_addr_r < 6'(ftj_pkg::MAX_WIDTH))),
    .waddr(wr_addr_r[4:0]),
    .wdata(word_rdata),
    .re   (gen_adv && (ph_r == PH_WORD)),
    .raddr(off_r),
    .rdata(line_rdata)
  );

  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 5'(ftj_pkg::MAX_WORDS))
    else $error("line word count above limit");

  a_text_len: assert property (@(posedge clk) disable iff (!rst_n)
    t_r <= 6'(ftj_pkg::MAX_WIDTH))
    else $error("line text length above line store size");

  a_gen_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> (n_r != 5'd0))
    else $error("line emitted with no words");

endmodule

// ----- design/full_text_justifier_core.sv -----
// Top level of the full text justifier: width register, front end, queue, line builder.
// Uses ftj_pkg, the channel interfaces, ftj_front, ftj_cmd_fifo and ftj_back.
//
// Usage: characters enter on in_ch, one character per handshake, each with word_end and
// text_end marks. Justified lines leave on out_ch, one character per handshake, every
// line exactly line_width characters (0 acts as 1, above 32 as 32), with line_end
// on its last character, final_line on the flushed last line, and run_end on the
// last character caused by one input word. cfg_ch writes line_width; write it only
// while the block is idle.
// Throughput: characters inside a word are taken back to back. A word end queues an
// append and up to two line emits; the next character waits until the word is
// copied into the line store. A line streams at one character per cycle while the
// receiver takes them, after a bit-serial gap divide when it is justified, through
// the s1 stage and the output register. Intake overlaps line output while the
// four-entry queue has room, but an append waits for lines queued ahead of it.
// A stalled receiver freezes the line generator; the output register holds.
// Reset: line width 16, empty line and word, queue empty; no memory clearing.
module full_text_justifier_core (
  input  logic        clk,
  input  logic        rst_n,
  ftj_in_if.sink      in_ch,
  ftj_out_if.source   out_ch,
  ftj_cfg_if.sink     cfg_ch
);

  logic [5:0]          line_width_r;
  logic [5:0]          eff_width;
  logic                push;
  ftj_pkg::cmd_t       push_cmd;
  logic                pop;
  ftj_pkg::cmd_t       pop_cmd;
  ftj_pkg::fifo_stat_t fifo_stat;
  logic                append_done;
  logic                word_re;
  logic [4:0]          word_raddr;
  logic [7:0]          word_rdata;
  logic                out_valid;
  ftj_pkg::res_t       out_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= ftj_pkg::WIDTH_RESET;
    end else if (cfg_ch.valid) begin
      line_width_r <= cfg_ch.line_width;
    end
  end

  always_comb begin
    if (line_width_r == 6'd0) begin
      eff_width = 6'd1;
    end else if (line_width_r > 6'(ftj_pkg::MAX_WIDTH)) begin
      eff_width = 6'(ftj_pkg::MAX_WIDTH);
    end else begin
      eff_width = line_width_r;
    end
  end

  ftj_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .width      (eff_width),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .char_code  (in_ch.char_code),
    .word_end   (in_ch.word_end),
    .text_end   (in_ch.text_end),
    .push       (push),
    .push_cmd   (push_cmd),
    .fifo_stat  (fifo_stat),
    .append_done(append_done),
    .word_re    (word_re),
    .word_raddr (word_raddr),
    .word_rdata (word_rdata)
  );

  ftj_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_cmd),
    .pop      (pop),
    .pop_data (pop_cmd),
    .stat     (fifo_stat)
  );

  ftj_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .width      (eff_width),
    .fifo_stat  (fifo_stat),
    .pop        (pop),
    .cmd        (pop_cmd),
    .append_done(append_done),
    .word_re    (word_re),
    .word_raddr (word_raddr),
    .word_rdata (word_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_res    (out_res)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.out_char   = out_res.out_char;
  assign out_ch.line_end   = out_res.line_end;
  assign out_ch.final_line = out_res.final_line;
  assign out_ch.run_end    = out_res.run_end;

endmodule
